/* design/pls_pkg.sv */
`timescale 1ns / 1ps
// pls_pkg: operation codes, status codes and sequencer states of the list store.
// Used by positional_list_store; depends on nothing.
package pls_pkg;

    localparam int FUNC_W = 3;
    localparam int POS_W  = 5;
    localparam int STAT_W = 3;
    localparam int OUT_W  = 32;

    typedef enum logic [FUNC_W-1:0] {
        F_INS_TAIL = 3'd0,
        F_INS_HEAD = 3'd1,
        F_INS_POS  = 3'd2,
        F_DEL_HEAD = 3'd3,
        F_DEL_TAIL = 3'd4,
        F_DEL_POS  = 3'd5,
        F_SEARCH   = 3'd6,
        F_DUMP     = 3'd7
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_BAD_POS   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_SHIFT_INS = 6'b000010,
        S_DEL_GRAB  = 6'b000100,
        S_SHIFT_DEL = 6'b001000,
        S_SCAN      = 6'b010000,
        S_DUMP      = 6'b100000
    } state_t;

endpackage

/* design/pls_ram.sv */
`timescale 1ns / 1ps
// pls_ram: element storage, one write port and one read port with registered
// read data. Stand-alone; no package needed.
module pls_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = 4
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/positional_list_store.sv */
`timescale 1ns / 1ps
// positional_list_store: ordered list of signed values with positional insert,
// delete, search and dump. Depends on pls_pkg and pls_ram.
//
//  channel   handshake            payload
//  -------   ------------------   -------------------------------------
//  command   start / busy         func, value, position
//  result    strobe (one cycle)   status, value_out, found_at, last
//
// A command is taken on a clock edge with start high and busy low. Commands
// that fail, and inserts at the tail, answer in the next cycle without going busy.
// Other inserts and deletes, search and dump go busy, and a dump gives one result
// per cycle; every step goes through the single memory read and write port,
// one element per cycle.
// rst_n clears the length and the sequencer; element storage is not cleared.
// Results are shown for one cycle and cannot be held off by the receiver.
module positional_list_store
    import pls_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [FUNC_W-1:0]        func,
    input  logic signed [31:0]       value,
    input  logic [POS_W-1:0]         position,
    output logic                     strobe,
    output logic [STAT_W-1:0]        status,
    output logic signed [OUT_W-1:0]  value_out,
    output logic [POS_W-1:0]         found_at,
    output logic                     last
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CW    = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    state_t                  state_reg, state_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [AW-1:0]           w_reg, w_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic [VALUE_BITS-1:0]   data_reg, data_next;

    logic                    strobe_reg;
    logic [STAT_W-1:0]       status_reg;
    logic signed [OUT_W-1:0] value_out_reg;
    logic [POS_W-1:0]        found_at_reg;
    logic                    last_reg;

    logic                    emit;
    status_t                 e_status;
    logic signed [OUT_W-1:0] e_value;
    logic [POS_W-1:0]        e_found;
    logic                    e_last;

    logic                    wr_en, rd_en;
    logic [AW-1:0]           wr_addr, rd_addr;
    logic [VALUE_BITS-1:0]   wr_data, rd_data;

    logic [VALUE_BITS-1:0]   val_st;
    logic [CW-1:0]           pos_c, len_c, wc;
    logic                    bad_ins, bad_del;
    logic [AW-1:0]           ins_idx, del_idx;
    func_t                   op;

    assign op      = func_t'(func);
    assign val_st  = VALUE_BITS'(value);
    assign pos_c   = CW'(position);
    assign len_c   = CW'(len_reg);
    assign wc      = CW'(w_reg);
    assign bad_ins = (pos_c == '0) || (pos_c > len_c + CW'(1));
    assign bad_del = (pos_c == '0) || (pos_c > len_c);

    always_comb
    begin
        if (op == F_INS_TAIL)
        begin
            ins_idx = AW'(len_reg);
        end
        else if (op == F_INS_HEAD || len_reg == '0)
        begin
            ins_idx = '0;
        end
        else
        begin
            ins_idx = AW'(pos_c - CW'(1));
        end
    end

    always_comb
    begin
        if (op == F_DEL_HEAD)
        begin
            del_idx = '0;
        end
        else if (op == F_DEL_TAIL)
        begin
            del_idx = AW'(len_c - CW'(1));
        end
        else
        begin
            del_idx = AW'(pos_c - CW'(1));
        end
    end

    pls_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_BITS),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        w_next     = w_reg;
        idx_next   = idx_reg;
        data_next  = data_reg;
        rd_en      = 1'b0;
        rd_addr    = w_reg;
        wr_en      = 1'b0;
        wr_addr    = w_reg;
        wr_data    = rd_data;
        emit       = 1'b0;
        e_status   = ST_OK;
        e_value    = '0;
        e_found    = '0;
        e_last     = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (op)
                        F_INS_TAIL, F_INS_HEAD, F_INS_POS:
                        begin
                            if (len_c >= CAP_C)
                            begin
                                emit     = 1'b1;
                                e_status = ST_FULL;
                            end
                            else if (op == F_INS_POS && len_reg != '0 && bad_ins)
                            begin
                                emit     = 1'b1;
                                e_status = ST_BAD_POS;
                            end
                            else if (CW'(ins_idx) == len_c)
                            begin
                                // nothing to move: write straight at the end
                                wr_en    = 1'b1;
                                wr_addr  = ins_idx;
                                wr_data  = val_st;
                                len_next = len_reg + LEN_W'(1);
                                emit     = 1'b1;
                            end
                            else
                            begin
                                data_next  = val_st;
                                idx_next   = ins_idx;
                                w_next     = AW'(len_reg);
                                rd_en      = 1'b1;
                                rd_addr    = AW'(len_c - CW'(1));
                                state_next = S_SHIFT_INS;
                            end
                        end
                        F_DEL_HEAD, F_DEL_TAIL, F_DEL_POS:
                        begin
                            if (len_reg == '0)
                            begin
                                emit     = 1'b1;
                                e_status = ST_EMPTY;
                            end
                            else if (op == F_DEL_POS && bad_del)
                            begin
                                emit     = 1'b1;
                                e_status = ST_BAD_POS;
                            end
                            else
                            begin
                                idx_next   = del_idx;
                                rd_en      = 1'b1;
                                rd_addr    = del_idx;
                                state_next = S_DEL_GRAB;
                            end
                        end
                        F_SEARCH:
                        begin
                            if (len_reg == '0)
                            begin
                                emit     = 1'b1;
                                e_status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                data_next  = val_st;
                                w_next     = '0;
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_SCAN;
                            end
                        end
                        F_DUMP:
                        begin
                            if (len_reg == '0)
                            begin
                                emit     = 1'b1;
                                e_status = ST_EMPTY;
                            end
                            else
                            begin
                                w_next     = '0;
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_DUMP;
                            end
                        end
                    endcase
                end
            end
            S_SHIFT_INS:
            begin
                if (w_reg == idx_reg)
                begin
                    // gap is open: drop the new value in
                    wr_en      = 1'b1;
                    wr_addr    = idx_reg;
                    wr_data    = data_reg;
                    len_next   = len_reg + LEN_W'(1);
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // move entry w-1 up to w, fetch the one below it
                    wr_en   = 1'b1;
                    wr_addr = w_reg;
                    wr_data = rd_data;
                    w_next  = w_reg - AW'(1);
                    if (w_reg - AW'(1) != idx_reg)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = w_reg - AW'(2);
                    end
                end
            end
            S_DEL_GRAB:
            begin
                data_next  = rd_data;
                w_next     = idx_reg;
                state_next = S_SHIFT_DEL;
                if (CW'(idx_reg) + CW'(1) < len_c)
                begin
                    rd_en   = 1'b1;
                    rd_addr = idx_reg + AW'(1);
                end
            end
            S_SHIFT_DEL:
            begin
                if (wc + CW'(1) < len_c)
                begin
                    // move entry w+1 down to w, fetch the one after it
                    wr_en   = 1'b1;
                    wr_addr = w_reg;
                    wr_data = rd_data;
                    w_next  = w_reg + AW'(1);
                    if (wc + CW'(2) < len_c)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = w_reg + AW'(2);
                    end
                end
                else
                begin
                    len_next   = len_reg - LEN_W'(1);
                    emit       = 1'b1;
                    e_value    = OUT_W'(signed'(data_reg));
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (rd_data == data_reg)
                begin
                    emit       = 1'b1;
                    e_found    = POS_W'(wc + CW'(1));
                    state_next = S_IDLE;
                end
                else if (wc + CW'(1) == len_c)
                begin
                    emit       = 1'b1;
                    e_status   = ST_NOT_FOUND;
                    state_next = S_IDLE;
                end
                else
                begin
                    w_next  = w_reg + AW'(1);
                    rd_en   = 1'b1;
                    rd_addr = w_reg + AW'(1);
                end
            end
            S_DUMP:
            begin
                emit    = 1'b1;
                e_value = OUT_W'(signed'(rd_data));
                e_last  = (wc + CW'(1) == len_c);
                if (wc + CW'(1) == len_c)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    w_next  = w_reg + AW'(1);
                    rd_en   = 1'b1;
                    rd_addr = w_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            w_reg      <= '0;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            w_reg      <= w_next;
            idx_reg    <= idx_next;
            strobe_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (emit)
        begin
            status_reg    <= e_status;
            value_out_reg <= e_value;
            found_at_reg  <= e_found;
            last_reg      <= e_last;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign strobe    = strobe_reg;
    assign status    = status_reg;
    assign value_out = value_out_reg;
    assign found_at  = found_at_reg;
    assign last      = last_reg;

endmodule

/* tb/positional_list_store_test.sv */
`timescale 1ns / 1ps
// positional_list_store_test: self-checking bench for the list store; predicts every
// result from its own copy of the list and compares each strobed result in order.
// Depends on pls_pkg and positional_list_store.
module positional_list_store_test;
    import pls_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 270;
    localparam int QUIET_TAIL   = 40;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        status_t                 st;
        logic signed [OUT_W-1:0] val;
        logic [POS_W-1:0]        at;
        logic                    fin;
    } list_result_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [FUNC_W-1:0]        func;
    logic signed [31:0]       value;
    logic [POS_W-1:0]         position;
    logic                     strobe;
    logic [STAT_W-1:0]        status;
    logic signed [OUT_W-1:0]  value_out;
    logic [POS_W-1:0]         found_at;
    logic                     last;

    // predicted list contents, updated when an item is taken
    logic signed [31:0] list_vals [DEPTH];
    int                 list_len;
    list_result_t       awaited_results[$];

    int error_count;
    int results_checked;
    int cycle_count;
    int full_hits;
    int empty_hits;
    int ops_taken [8];

    positional_list_store #(
        .CAPACITY   (DEPTH),
        .VALUE_BITS (32)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .value     (value),
        .position  (position),
        .strobe    (strobe),
        .status    (status),
        .value_out (value_out),
        .found_at  (found_at),
        .last      (last)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void await_result(status_t st, logic signed [31:0] v,
                                         logic [POS_W-1:0] at, logic fin);
        list_result_t r;
        r.st  = st;
        r.val = v;
        r.at  = at;
        r.fin = fin;
        awaited_results.push_back(r);
        if (st == ST_FULL)
            full_hits++;
        if (st == ST_EMPTY)
            empty_hits++;
    endfunction

    // apply one operation to the predicted list and queue its results
    function automatic void apply_list_op(func_t f, logic signed [31:0] v,
                                          logic [POS_W-1:0] p);
        int                 idx;
        int                 pos_i;
        int                 i;
        logic signed [31:0] taken;
        idx   = -1;
        pos_i = p;
        ops_taken[f]++;
        case (f)
            F_INS_TAIL, F_INS_HEAD, F_INS_POS:
            begin
                if (list_len >= DEPTH)
                    await_result(ST_FULL, '0, '0, 1'b1);
                else
                begin
                    if (f == F_INS_TAIL)
                        idx = list_len;
                    else if (f == F_INS_HEAD || list_len == 0)
                        idx = 0;
                    else if (pos_i >= 1 && pos_i <= list_len + 1)
                        idx = pos_i - 1;
                    if (idx < 0)
                        await_result(ST_BAD_POS, '0, '0, 1'b1);
                    else
                    begin
                        for (i = list_len; i > idx; i--)
                            list_vals[i] = list_vals[i-1];
                        list_vals[idx] = v;
                        list_len++;
                        await_result(ST_OK, '0, '0, 1'b1);
                    end
                end
            end
            F_DEL_HEAD, F_DEL_TAIL, F_DEL_POS:
            begin
                if (list_len == 0)
                    await_result(ST_EMPTY, '0, '0, 1'b1);
                else
                begin
                    if (f == F_DEL_HEAD)
                        idx = 0;
                    else if (f == F_DEL_TAIL)
                        idx = list_len - 1;
                    else if (pos_i >= 1 && pos_i <= list_len)
                        idx = pos_i - 1;
                    if (idx < 0)
                        await_result(ST_BAD_POS, '0, '0, 1'b1);
                    else
                    begin
                        taken = list_vals[idx];
                        for (i = idx; i + 1 < list_len; i++)
                            list_vals[i] = list_vals[i+1];
                        list_len--;
                        await_result(ST_OK, taken, '0, 1'b1);
                    end
                end
            end
            F_SEARCH:
            begin
                for (i = 0; i < list_len && idx < 0; i++)
                    if (list_vals[i] == v)
                        idx = i;
                if (idx < 0)
                    await_result(ST_NOT_FOUND, '0, '0, 1'b1);
                else
                    await_result(ST_OK, '0, POS_W'(idx + 1), 1'b1);
            end
            default:
            begin
                if (list_len == 0)
                    await_result(ST_EMPTY, '0, '0, 1'b1);
                for (i = 0; i < list_len; i++)
                    await_result(ST_OK, list_vals[i], '0, (i + 1 == list_len));
            end
        endcase
    endfunction

    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] ERROR: %s", $time, msg);
    endfunction

    // take results first: a result never belongs to the item taken on the same edge
    always @(posedge clk)
    begin : watch
        list_result_t want;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (awaited_results.size() == 0)
                    note_error($sformatf("unexpected result st=%0d val=%0d at=%0d last=%0b",
                                         status, value_out, found_at, last));
                else
                begin
                    want = awaited_results.pop_front();
                    results_checked++;
                    if (status !== want.st || value_out !== want.val ||
                        found_at !== want.at || last !== want.fin)
                        note_error($sformatf(
                            "exp st=%0d val=%0d at=%0d last=%0b, got st=%0d val=%0d at=%0d last=%0b",
                            want.st, want.val, want.at, want.fin,
                            status, value_out, found_at, last));
                end
            end
            if (start && !busy)
                apply_list_op(func_t'(func), value, position);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // hold the item until the edge that takes it; start stays high afterwards
    task automatic send_item(func_t f, logic signed [31:0] v, logic [POS_W-1:0] p);
        start    <= 1'b1;
        func     <= f;
        value    <= v;
        position <= p;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic rest(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        rest(1);
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return $urandom_range(0, 7);
        if (r < 30)
            return 32'h7fff_ffff;
        if (r < 35)
            return 32'h8000_0000;
        return $urandom;
    endfunction

    task automatic test_empty_list();
        send_item(F_DUMP, 0, 0);
        send_item(F_DEL_HEAD, 0, 0);
        send_item(F_DEL_TAIL, 0, 0);
        send_item(F_DEL_POS, 0, 1);
        send_item(F_SEARCH, 0, 0);
        // any position is accepted on an empty list
        send_item(F_INS_POS, -1, 31);
        send_item(F_SEARCH, -1, 0);
        send_item(F_DEL_TAIL, 0, 0);
        send_item(F_INS_POS, 5, 0);
        send_item(F_DEL_POS, 0, 0);
        send_item(F_DEL_POS, 0, 1);
        drain();
    endtask

    task automatic test_insert_positions();
        send_item(F_INS_TAIL, 32'h7fff_ffff, 0);
        send_item(F_INS_HEAD, 32'h8000_0000, 0);
        send_item(F_INS_POS, 0, 1);
        send_item(F_INS_POS, 1, 4);
        send_item(F_INS_POS, 2, 6);
        send_item(F_INS_POS, 3, 0);
        send_item(F_DUMP, 0, 0);
        drain();
    endtask

    task automatic test_full_list();
        int n;
        n = list_len;
        repeat (DEPTH - list_len)
        begin
            send_item(F_INS_POS, $urandom, POS_W'($urandom_range(1, n + 1)));
            n++;
        end
        send_item(F_INS_TAIL, 9, 0);
        send_item(F_INS_HEAD, 9, 0);
        send_item(F_INS_POS, 9, 1);
        send_item(F_SEARCH, 0, 0);
        send_item(F_SEARCH, 32'h1234_5679, 0);
        send_item(F_DUMP, 0, 0);
        drain();
    endtask

    task automatic test_delete_positions();
        send_item(F_DEL_POS, 0, 17);
        send_item(F_DEL_POS, 0, 0);
        send_item(F_DEL_POS, 0, 16);
        send_item(F_DEL_POS, 0, 1);
        send_item(F_DEL_HEAD, 0, 0);
        send_item(F_DEL_TAIL, 0, 0);
        send_item(F_DUMP, 0, 0);
        drain();
    endtask

    // swing the list between empty and full so both ends are hit repeatedly
    task automatic test_random_traffic();
        int                 n;
        int                 r;
        int                 len_now;
        bit                 grow;
        func_t              f;
        logic signed [31:0] v;
        logic [POS_W-1:0]   p;
        grow = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            len_now = list_len;
            if (len_now >= DEPTH && $urandom_range(0, 3) == 0)
                grow = 1'b0;
            if (len_now == 0 && $urandom_range(0, 3) == 0)
                grow = 1'b1;
            r = $urandom_range(0, 99);
            v = pick_value();
            if (r < 6)
                f = F_DUMP;
            else if (r < 20)
            begin
                f = F_SEARCH;
                if (len_now > 0 && $urandom_range(0, 1) == 1)
                    v = list_vals[$urandom_range(0, len_now - 1)];
            end
            else if (r < (grow ? 72 : 40))
                f = func_t'($urandom_range(F_INS_TAIL, F_INS_POS));
            else
                f = func_t'($urandom_range(F_DEL_HEAD, F_DEL_POS));
            if ($urandom_range(0, 4) == 0)
                p = POS_W'($urandom_range(0, 31));
            else
                p = POS_W'($urandom_range(1, len_now + 1));
            send_item(f, v, p);
            if (n == RANDOM_ITEMS / 2)
                drain();
            else if (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 5) == 0)
                rest($urandom_range(1, 13));
        end
        rest(0);
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        start    <= 1'b0;
        func     <= F_INS_TAIL;
        value    <= '0;
        position <= '0;
        list_len = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_insert_positions();
        test_full_list();
        test_delete_positions();
        test_random_traffic();

        drain();
        // allow a full dump to finish before looking for stray results
        repeat (40) @(posedge clk);
        if (awaited_results.size() != 0)
            note_error($sformatf("%0d results never arrived", awaited_results.size()));

        $display("Covered %0d items (%0d dumps, %0d searches), %0d results checked",
                 ops_taken.sum(), ops_taken[F_DUMP], ops_taken[F_SEARCH], results_checked);
        $display("List hit full %0d times and empty %0d times, %0d mismatches",
                 full_hits, empty_hits, error_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
